// ===== rtl/esg_pkg.sv =====
// Shared constants for the exponential sweep generator.
// Configuration register indexes, field widths and parameter defaults.
// No dependencies.
package esg_pkg;

    localparam int MAX_SAMPLES_DEF    = 16777216;
    localparam int SINE_ADDR_BITS_DEF = 12;

    localparam int DATA_W  = 32;
    localparam int COUNT_W = 25;
    localparam int INDEX_W = 24;
    localparam int CFG_IDX_W = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START_PHASE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_STEP   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_RATIO   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_GAIN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_RATIO   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT = 3'd5;

    localparam logic [DATA_W-1:0] ONE_Q2_30  = 32'h4000_0000;
    localparam logic [DATA_W-1:0] ONE_Q12_20 = 32'h0010_0000;

    localparam longint TWO_PI_Q30 = 64'sd6746518852;
    localparam longint ONE_Q30    = 64'sd1073741824;

endpackage

// ===== rtl/exponential_sweep_generator.sv =====
// Exponential sine sweep generator: top level.
// Depends on esg_pkg (register indexes, widths, sine table constants).
//
// Usage:
//   Each request on the s_ channel (s_valid/s_ready) carries s_restart. A
//   request with s_restart high reloads start phase, step and gain and
//   yields sample 0; otherwise it yields the next sample of the sweep.
//   One result per request leaves on the m_ channel (m_valid/m_ready):
//   m_sample (Q12.20 amplitude times sine, saturated), m_sample_index,
//   m_last on the final sample, m_done_res with a zero sample once the
//   sweep is over or sample_count is zero.
//   Configuration is a plain write port (cfg_we, cfg_index, cfg_wdata);
//   the user must write it only while the block is idle; the block itself does not enforce this.
// Timing:
//   Results are registered: the state update and the registered sine ROM
//   read come first, then the amplitude multiply into the output register.
//   Throughput is one request per cycle while m_ready does not stall the
//   output; the phase, step and gain recurrences are each computed combinationally.
// Reset (aresetn low, synchronous): configuration and sweep state registers
//   go to their defaults, the sweep is marked finished, and the pipeline empties.
// Stall: while m_ready is low the result holds; if the middle stage is empty,
//   one more request is taken into it, then s_ready drops.
module exponential_sweep_generator #(
    parameter int MAX_SAMPLES    = esg_pkg::MAX_SAMPLES_DEF,
    parameter int SINE_ADDR_BITS = esg_pkg::SINE_ADDR_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [esg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [esg_pkg::DATA_W-1:0]      cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_restart,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic signed [esg_pkg::DATA_W-1:0] m_sample,
    output logic [esg_pkg::INDEX_W-1:0]     m_sample_index,
    output logic                            m_last,
    output logic                            m_done_res
);
    import esg_pkg::*;

    localparam int POS_W     = $clog2(MAX_SAMPLES) + 1;
    localparam int SINE_SIZE = 1 << SINE_ADDR_BITS;
    localparam int QUARTER   = SINE_SIZE / 4;

    typedef logic signed [15:0] sine_rom_t [SINE_SIZE];

    // Q1.15 quarter-wave entry from an 8-term Taylor series in Q30
    function automatic logic signed [15:0] quarter_sine(input int k);
        longint x;
        longint x2;
        longint term;
        longint sum;
        longint v;
        x    = (TWO_PI_Q30 * longint'(k)) / SINE_SIZE;
        x2   = (x * x) / ONE_Q30;
        term = x;
        sum  = x;
        term = -((term * x2) / ONE_Q30); term = term / 6;   sum = sum + term;
        term = -((term * x2) / ONE_Q30); term = term / 20;  sum = sum + term;
        term = -((term * x2) / ONE_Q30); term = term / 42;  sum = sum + term;
        term = -((term * x2) / ONE_Q30); term = term / 72;  sum = sum + term;
        term = -((term * x2) / ONE_Q30); term = term / 110; sum = sum + term;
        term = -((term * x2) / ONE_Q30); term = term / 156; sum = sum + term;
        term = -((term * x2) / ONE_Q30); term = term / 210; sum = sum + term;
        if (sum < 0) sum = 0;
        if (sum > ONE_Q30) sum = ONE_Q30;
        v = (sum * 32767 + ONE_Q30 / 2) / ONE_Q30;
        if (v > 32767) v = 32767;
        return 16'(v);
    endfunction

    function automatic sine_rom_t build_rom();
        sine_rom_t rom;
        for (int k = 0; k < SINE_SIZE; k++) begin
            if (k <= QUARTER)
                rom[k] = quarter_sine(k);
            else if (k <= 2 * QUARTER)
                rom[k] = quarter_sine(2 * QUARTER - k);
            else if (k <= 3 * QUARTER)
                rom[k] = -quarter_sine(k - 2 * QUARTER);
            else
                rom[k] = -quarter_sine(4 * QUARTER - k);
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_rom();

    // configuration registers
    logic [DATA_W-1:0]  start_phase_reg, start_step_reg, step_ratio_reg;
    logic [DATA_W-1:0]  start_gain_reg, gain_ratio_reg;
    logic [COUNT_W-1:0] sample_count_reg;

    // sweep state
    logic [DATA_W-1:0] phase_acc_reg, phase_step_reg, amplitude_reg;
    logic [POS_W-1:0]  position_reg;
    logic [DATA_W-1:0] phase_acc_next, phase_step_next, amplitude_next;
    logic [POS_W-1:0]  position_next;

    // pipeline
    logic                         v1_reg, v2_reg;
    logic                         en1, en2, accept;
    logic signed [15:0]           sine_s1_reg;
    logic [DATA_W-1:0]            amp_s1_reg;
    logic [INDEX_W-1:0]           idx_s1_reg;
    logic                         last_s1_reg, done_s1_reg;
    logic signed [DATA_W-1:0]     sample_reg;
    logic [INDEX_W-1:0]           index_reg;
    logic                         last_reg, done_reg;

    // stage 0 signals
    logic [DATA_W-1:0]  phase_eff, step_eff, amp_eff;
    logic [POS_W-1:0]   pos_eff;
    logic [COUNT_W-1:0] count_eff;
    logic               finished, is_last;
    logic [SINE_ADDR_BITS-1:0] rom_addr;
    logic signed [2*DATA_W-1:0] step_prod;
    logic [2*DATA_W-1:0]        gain_prod;
    logic signed [DATA_W+16:0]  samp_prod;
    logic signed [DATA_W+1:0]   samp_shift;
    logic signed [DATA_W-1:0]   samp_sat;

    assign en2     = !v2_reg || m_ready;
    assign en1     = !v1_reg || en2;
    assign s_ready = en1;
    assign accept  = s_valid && en1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_phase_reg  <= '0;
            start_step_reg   <= '0;
            step_ratio_reg   <= ONE_Q2_30;
            start_gain_reg   <= ONE_Q12_20;
            gain_ratio_reg   <= ONE_Q2_30;
            sample_count_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_START_PHASE:  start_phase_reg  <= cfg_wdata;
                CFG_START_STEP:   start_step_reg   <= cfg_wdata;
                CFG_STEP_RATIO:   step_ratio_reg   <= cfg_wdata;
                CFG_START_GAIN:   start_gain_reg   <= cfg_wdata;
                CFG_GAIN_RATIO:   gain_ratio_reg   <= cfg_wdata;
                CFG_SAMPLE_COUNT: sample_count_reg <= cfg_wdata[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // stage 0: pick start or running state, then advance it
    always_comb begin
        phase_eff = s_restart ? start_phase_reg : phase_acc_reg;
        step_eff  = s_restart ? start_step_reg  : phase_step_reg;
        amp_eff   = s_restart ? start_gain_reg  : amplitude_reg;
        pos_eff   = s_restart ? '0 : position_reg;
        count_eff = (sample_count_reg > COUNT_W'(MAX_SAMPLES)) ?
                    COUNT_W'(MAX_SAMPLES) : sample_count_reg;
        finished  = COUNT_W'(pos_eff) >= count_eff;
        is_last   = (COUNT_W'(pos_eff) + COUNT_W'(1)) == count_eff;
        rom_addr  = phase_eff[DATA_W-1 -: SINE_ADDR_BITS];

        step_prod = $signed(step_eff) * $signed({1'b0, step_ratio_reg});
        gain_prod = amp_eff * gain_ratio_reg;

        if (finished) begin
            phase_acc_next  = phase_eff;
            phase_step_next = step_eff;
            amplitude_next  = amp_eff;
            position_next   = pos_eff;
        end else begin
            phase_acc_next  = phase_eff + step_eff;
            phase_step_next = step_prod[DATA_W+29:30];
            amplitude_next  = (|gain_prod[2*DATA_W-1:DATA_W+30]) ? '1 :
                              gain_prod[DATA_W+29:30];
            position_next   = pos_eff + POS_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_acc_reg  <= '0;
            phase_step_reg <= '0;
            amplitude_reg  <= '0;
            position_reg   <= POS_W'(MAX_SAMPLES);
        end else if (accept) begin
            phase_acc_reg  <= phase_acc_next;
            phase_step_reg <= phase_step_next;
            amplitude_reg  <= amplitude_next;
            position_reg   <= position_next;
        end
    end

    // stage 1: registered sine ROM read plus carried fields
    always_ff @(posedge aclk) begin
        if (en1) begin
            sine_s1_reg <= SINE_ROM[rom_addr];
            amp_s1_reg  <= amp_eff;
            idx_s1_reg  <= finished ? '0 : INDEX_W'(pos_eff);
            last_s1_reg <= !finished && is_last;
            done_s1_reg <= finished;
        end
    end

    // stage 2: amplitude times sine, floor shift by 15, saturate
    always_comb begin
        samp_prod  = $signed({1'b0, amp_s1_reg}) * sine_s1_reg;
        samp_shift = samp_prod[DATA_W+16:15];
        if (samp_shift[DATA_W+1:DATA_W-1] == 3'b000 ||
            samp_shift[DATA_W+1:DATA_W-1] == 3'b111)
            samp_sat = samp_shift[DATA_W-1:0];
        else if (samp_shift[DATA_W+1])
            samp_sat = {1'b1, {(DATA_W-1){1'b0}}};
        else
            samp_sat = {1'b0, {(DATA_W-1){1'b1}}};
    end

    always_ff @(posedge aclk) begin
        if (en2) begin
            sample_reg <= done_s1_reg ? '0 : samp_sat;
            index_reg  <= idx_s1_reg;
            last_reg   <= last_s1_reg;
            done_reg   <= done_s1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= s_valid;
            if (en2) v2_reg <= v1_reg;
        end
    end

    assign m_valid        = v2_reg;
    assign m_sample       = sample_reg;
    assign m_sample_index = index_reg;
    assign m_last         = last_reg;
    assign m_done_res     = done_reg;

endmodule

// ===== rtl/esg_checker.sv =====
// Port-level checks for the exponential sweep generator, bound to the top.
// Depends on esg_pkg for field widths.
module esg_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               m_valid,
    input logic                               m_ready,
    input logic signed [esg_pkg::DATA_W-1:0]  m_sample,
    input logic [esg_pkg::INDEX_W-1:0]        m_sample_index,
    input logic                               m_last,
    input logic                               m_done_res
);
    import esg_pkg::*;

    // a finished-sweep result carries nothing but the flag
    a_done_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_done_res |-> m_sample == '0 && m_sample_index == '0 && !m_last)
        else $error("done result with nonzero payload");

    a_last_not_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_last && m_done_res))
        else $error("last and done_res both set");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_sample) && $stable(m_sample_index))
        else $error("stalled result changed");

endmodule

bind exponential_sweep_generator esg_checker u_esg_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_sample       (m_sample),
    .m_sample_index (m_sample_index),
    .m_last         (m_last),
    .m_done_res     (m_done_res)
);
